FILE: design/rnv12_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnv12_pkg
// Shared types and constants of the rgb to nv12 nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package rnv12_pkg;

  // size limits
  localparam int MAX_DIM     = 4096;
  localparam int MAX_UPSCALE = 4;

  // field and internal widths
  localparam int DIM_W     = 13;  // sizes, map quotients and remainders
  localparam int COORD_W   = 12;  // source and destination coordinates
  localparam int SAMP_W    = 8;   // color and sample values
  localparam int MUL_W     = 15;  // upscale times source size
  localparam int INC_W     = $clog2(MAX_UPSCALE + 1);
  localparam int CFG_IDX_W = 2;
  localparam int COL_W     = 18;  // signed color sums

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  // configuration reset values
  localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 13'd1080;
  localparam logic [DIM_W-1:0] RST_DST_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RST_DST_HEIGHT = 13'd1080;

  // plane codes
  localparam logic PLANE_LUMA   = 1'b0;
  localparam logic PLANE_CHROMA = 1'b1;

  // bt.601 studio-range coefficients
  localparam logic signed [COL_W-1:0] COEF_YR = 18'sd66;
  localparam logic signed [COL_W-1:0] COEF_YG = 18'sd129;
  localparam logic signed [COL_W-1:0] COEF_YB = 18'sd25;
  localparam logic signed [COL_W-1:0] COEF_UR = -18'sd38;
  localparam logic signed [COL_W-1:0] COEF_UG = -18'sd74;
  localparam logic signed [COL_W-1:0] COEF_UB = 18'sd112;
  localparam logic signed [COL_W-1:0] COEF_VR = 18'sd112;
  localparam logic signed [COL_W-1:0] COEF_VG = -18'sd94;
  localparam logic signed [COL_W-1:0] COEF_VB = -18'sd18;
  localparam logic signed [COL_W-1:0] COL_RND = 18'sd128;
  localparam logic [SAMP_W-1:0] LUMA_OFS   = 8'd16;
  localparam logic [SAMP_W-1:0] CHROMA_OFS = 8'd128;

  // source pixel
  typedef struct packed {
    logic [SAMP_W-1:0] blue;
    logic [SAMP_W-1:0] green;
    logic [SAMP_W-1:0] red;
  } pix_t;

  // result item
  typedef struct packed {
    logic               plane;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [SAMP_W-1:0]  sample_first;
    logic [SAMP_W-1:0]  sample_second;
    logic               last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // latch pixel, first map step, advance position
    logic map;          // second map step and color conversion
    logic init_luma;    // load luma scan start
    logic init_chroma;  // load chroma scan start
    logic emit;         // load output register
    logic step;         // advance scan counters
    logic plane;        // plane of emit and step
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic luma_empty;
    logic chroma_empty;
    logic luma_end;
    logic chroma_end;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

FILE: design/rnv12_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnv12_pix_if
// Valid/ready channel carrying one source pixel per transaction.
// ----------------------------------------------------------------------------
interface rnv12_pix_if import rnv12_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/rnv12_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnv12_res_if
// Valid/ready channel carrying one luma sample or chroma pair per transaction.
// ----------------------------------------------------------------------------
interface rnv12_res_if import rnv12_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/rgb_to_nv12_nearest_scaler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_nv12_nearest_scaler_unit
// Raster rgb pixels in, nearest-neighbor scaled bt.601 luma samples and
// interleaved chroma pairs out, each tagged with its destination position.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  pix_i    in   valid / ready           blue, green, red
//  res_o    out  valid / ready           plane, dest_x, dest_y, sample_first,
//                                        sample_second, last
//  cfg      in   cfg_we_i, no back-pressure  cfg_idx_i, cfg_data_i
//
//  a pixel passes through the accept, map and plan states and then emits its
//  results; the map takes two passes through the column and row steppers.
//  results drain through a single output register; a stalled res_o holds the
//  sequencer, and pix_i is taken again once the last result is registered.
//  reset loads the default frame sizes and returns the position to 0,0;
//  any configuration write does the same for the position.
// ----------------------------------------------------------------------------
module rgb_to_nv12_nearest_scaler_unit import rnv12_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rnv12_pix_if.sink            pix_i,
  rnv12_res_if.source          res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      pix_ready;
  logic      res_valid;
  res_t      res_data;

  // sequencer
  rnv12_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  rnv12_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_data_i  (pix_i.data),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign pix_i.ready = pix_ready;
  assign res_o.valid = res_valid;
  assign res_o.data  = res_data;

endmodule
`default_nettype wire

FILE: design/rnv12_stepper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnv12_stepper
// Advances ceil(k*d/s) from index k to k+1 as quotient and remainder.
// ----------------------------------------------------------------------------
module rnv12_stepper import rnv12_pkg::*; (
  input  logic [DIM_W-1:0] q_i,
  input  logic [DIM_W-1:0] r_i,
  input  logic [DIM_W-1:0] d_i,
  input  logic [DIM_W-1:0] s_i,
  output logic [DIM_W-1:0] q_o,
  output logic [DIM_W-1:0] r_o
);

  logic [MUL_W-1:0] sum;
  logic [MUL_W-1:0] sub;
  logic [INC_W-1:0] inc;

  // remainder plus d stays below (upscale + 1) * s, so pick the largest multiple
  always_comb begin
    sum = MUL_W'(r_i) + MUL_W'(d_i);
    inc = '0;
    sub = '0;
    for (int k = 1; k <= MAX_UPSCALE; k++) begin
      if (sum >= MUL_W'(k) * MUL_W'(s_i)) begin
        inc = INC_W'(k);
        sub = MUL_W'(k) * MUL_W'(s_i);
      end
    end
  end

  assign q_o = q_i + DIM_W'(inc);
  assign r_o = DIM_W'(sum - sub);

endmodule
`default_nettype wire

FILE: design/rnv12_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnv12_ctrl
// Sequencer: takes a pixel, maps it, then walks its luma and chroma results.
// ----------------------------------------------------------------------------
module rnv12_ctrl import rnv12_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pix_valid_i,
  output logic      pix_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAP    = 3'd1;
  localparam logic [2:0] ST_PLAN   = 3'd2;
  localparam logic [2:0] ST_LUMA   = 3'd3;
  localparam logic [2:0] ST_CHROMA = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    pix_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pix_ready_o = 1'b1;
        if (pix_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = ST_PLAN;
      end
      ST_PLAN: begin
        if (!sts_i.luma_empty) begin
          cmd_o.init_luma = 1'b1;
          state_d         = ST_LUMA;
        end else if (!sts_i.chroma_empty) begin
          cmd_o.init_chroma = 1'b1;
          state_d           = ST_CHROMA;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LUMA: begin
        cmd_o.plane = PLANE_LUMA;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.step = 1'b1;
          if (sts_i.luma_end) begin
            if (!sts_i.chroma_empty) begin
              cmd_o.init_chroma = 1'b1;
              state_d           = ST_CHROMA;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_CHROMA: begin
        cmd_o.plane = PLANE_CHROMA;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.step = 1'b1;
          if (sts_i.chroma_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/rnv12_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnv12_dp
// Datapath: configuration, source position, coordinate mapping, color
// conversion, scan counters and the output register.
// ----------------------------------------------------------------------------
module rnv12_dp import rnv12_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  pix_t                 pix_data_i,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output res_t                 res_data_o,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o
);

  function automatic logic [DIM_W-1:0] clamp_src(input logic [DIM_W-1:0] s);
    logic [DIM_W-1:0] v;
    v = s;
    if (v == '0) v = DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) v = DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dst(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] s);
    logic [MUL_W-1:0] lim;
    logic [MUL_W-1:0] v;
    lim = MUL_W'(MAX_UPSCALE) * MUL_W'(s);
    v   = MUL_W'(d);
    if (v > lim) v = lim;
    if (v > MUL_W'(MAX_DIM)) v = MUL_W'(MAX_DIM);
    return DIM_W'(v);
  endfunction

  function automatic logic [DIM_W-1:0] umin(input logic [DIM_W-1:0] a,
                                            input logic [DIM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // configuration
  logic [DIM_W-1:0] sw_q, sh_q, dw_q, dh_q;
  logic [DIM_W-1:0] sw_c, sh_c, dw_c, dh_c;

  // source position and map state at the current column and row
  logic [COORD_W-1:0] src_col_q, src_row_q;
  logic               col_fresh_q, row_fresh_q;
  logic [DIM_W-1:0]   col_q_q, col_r_q, row_q_q, row_r_q;
  logic [DIM_W-1:0]   col_eff_q, col_eff_r, row_eff_q, row_eff_r;
  logic               col_last, row_last;

  // stepper ports
  logic [DIM_W-1:0] col_in_q, col_in_r, col_nq, col_nr;
  logic [DIM_W-1:0] row_in_q, row_in_r, row_nq, row_nr;

  // per-pixel bounds and samples
  pix_t             rgb_q;
  logic             chroma_en_q;
  logic [DIM_W-1:0] x0_q, x1_q, y0_q, y1_q, cx1_q, cy1_q;
  logic [DIM_W-1:0] x1_raw_q, x1_rem_q, y1_raw_q, y1_rem_q;
  logic [DIM_W-1:0] ex0, ey0;
  logic [SAMP_W-1:0] luma_q, u_q, v_q;
  logic signed [COL_W-1:0] r_s, g_s, b_s, y_sum, u_sum, v_sum;

  // scan counters and output register
  logic [DIM_W-1:0] cur_x_q, cur_y_q;
  logic [DIM_W-1:0] x_inc1, y_inc1, x_inc2, y_inc2;
  logic             out_vld_q;
  res_t             res_q, res_d;

  assign sw_c = clamp_src(sw_q);
  assign sh_c = clamp_src(sh_q);
  assign dw_c = clamp_dst(dw_q, sw_c);
  assign dh_c = clamp_dst(dh_q, sh_c);

  // a fresh map state stands for index zero: quotient 0, remainder s - 1
  assign col_eff_q = col_fresh_q ? '0 : col_q_q;
  assign col_eff_r = col_fresh_q ? (sw_c - DIM_W'(1)) : col_r_q;
  assign row_eff_q = row_fresh_q ? '0 : row_q_q;
  assign row_eff_r = row_fresh_q ? (sh_c - DIM_W'(1)) : row_r_q;

  assign col_last = (DIM_W'(src_col_q) + DIM_W'(1)) >= sw_c;
  assign row_last = (DIM_W'(src_row_q) + DIM_W'(1)) >= sh_c;

  // steppers: next index on accept, index plus two during map
  assign col_in_q = cmd_i.map ? x1_raw_q : col_eff_q;
  assign col_in_r = cmd_i.map ? x1_rem_q : col_eff_r;
  assign row_in_q = cmd_i.map ? y1_raw_q : row_eff_q;
  assign row_in_r = cmd_i.map ? y1_rem_q : row_eff_r;

  rnv12_stepper u_col_step (
    .q_i (col_in_q),
    .r_i (col_in_r),
    .d_i (dw_c),
    .s_i (sw_c),
    .q_o (col_nq),
    .r_o (col_nr)
  );

  rnv12_stepper u_row_step (
    .q_i (row_in_q),
    .r_i (row_in_r),
    .d_i (dh_c),
    .s_i (sh_c),
    .q_o (row_nq),
    .r_o (row_nr)
  );

  // configuration registers and source position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q        <= RST_SRC_WIDTH;
      sh_q        <= RST_SRC_HEIGHT;
      dw_q        <= RST_DST_WIDTH;
      dh_q        <= RST_DST_HEIGHT;
      src_col_q   <= '0;
      src_row_q   <= '0;
      col_fresh_q <= 1'b1;
      row_fresh_q <= 1'b1;
      col_q_q     <= '0;
      col_r_q     <= '0;
      row_q_q     <= '0;
      row_r_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_WIDTH:  sw_q <= cfg_data_i;
        REG_SRC_HEIGHT: sh_q <= cfg_data_i;
        REG_DST_WIDTH:  dw_q <= cfg_data_i;
        REG_DST_HEIGHT: dh_q <= cfg_data_i;
        default: ;
      endcase
      src_col_q   <= '0;
      src_row_q   <= '0;
      col_fresh_q <= 1'b1;
      row_fresh_q <= 1'b1;
    end else if (cmd_i.accept) begin
      if (col_last) begin
        src_col_q   <= '0;
        col_fresh_q <= 1'b1;
        if (row_last) begin
          src_row_q   <= '0;
          row_fresh_q <= 1'b1;
        end else begin
          src_row_q   <= src_row_q + COORD_W'(1);
          row_fresh_q <= 1'b0;
          row_q_q     <= row_nq;
          row_r_q     <= row_nr;
        end
      end else begin
        src_col_q   <= src_col_q + COORD_W'(1);
        col_fresh_q <= 1'b0;
        col_q_q     <= col_nq;
        col_r_q     <= col_nr;
      end
    end
  end

  // color conversion, floor shift by eight keeps bits 15:8
  always_comb begin
    r_s   = signed'(COL_W'(rgb_q.red));
    g_s   = signed'(COL_W'(rgb_q.green));
    b_s   = signed'(COL_W'(rgb_q.blue));
    y_sum = COEF_YR * r_s + COEF_YG * g_s + COEF_YB * b_s + COL_RND;
    u_sum = COEF_UR * r_s + COEF_UG * g_s + COEF_UB * b_s + COL_RND;
    v_sum = COEF_VR * r_s + COEF_VG * g_s + COEF_VB * b_s + COL_RND;
  end

  // pixel bounds and samples
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rgb_q       <= pix_data_i;
      chroma_en_q <= ~src_col_q[0] & ~src_row_q[0];
      x0_q        <= umin(col_eff_q, dw_c);
      y0_q        <= umin(row_eff_q, dh_c);
      x1_q        <= umin(col_nq, dw_c);
      y1_q        <= umin(row_nq, dh_c);
      x1_raw_q    <= col_nq;
      x1_rem_q    <= col_nr;
      y1_raw_q    <= row_nq;
      y1_rem_q    <= row_nr;
    end
    if (cmd_i.map) begin
      cx1_q  <= umin(col_nq, dw_c);
      cy1_q  <= umin(row_nq, dh_c);
      luma_q <= y_sum[15:8] + LUMA_OFS;
      u_q    <= u_sum[15:8] + CHROMA_OFS;
      v_q    <= v_sum[15:8] + CHROMA_OFS;
    end
  end

  // chroma scan starts at the first even position
  assign ex0 = x0_q + DIM_W'(x0_q[0]);
  assign ey0 = y0_q + DIM_W'(y0_q[0]);

  assign x_inc1 = cur_x_q + DIM_W'(1);
  assign y_inc1 = cur_y_q + DIM_W'(1);
  assign x_inc2 = cur_x_q + DIM_W'(2);
  assign y_inc2 = cur_y_q + DIM_W'(2);

  // status to the controller
  assign sts_o.luma_empty   = (x0_q >= x1_q) || (y0_q >= y1_q);
  assign sts_o.chroma_empty = !chroma_en_q || (ex0 >= cx1_q) || (ey0 >= cy1_q);
  assign sts_o.luma_end     = (x_inc1 >= x1_q) && (y_inc1 >= y1_q);
  assign sts_o.chroma_end   = (x_inc2 >= cx1_q) && (y_inc2 >= cy1_q);
  assign sts_o.out_free     = !out_vld_q || res_ready_i;

  // scan counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_luma) begin
      cur_x_q <= x0_q;
      cur_y_q <= y0_q;
    end else if (cmd_i.init_chroma) begin
      cur_x_q <= ex0;
      cur_y_q <= ey0;
    end else if (cmd_i.step) begin
      if (cmd_i.plane == PLANE_LUMA) begin
        if (x_inc1 < x1_q) begin
          cur_x_q <= x_inc1;
        end else begin
          cur_x_q <= x0_q;
          cur_y_q <= y_inc1;
        end
      end else begin
        if (x_inc2 < cx1_q) begin
          cur_x_q <= x_inc2;
        end else begin
          cur_x_q <= ex0;
          cur_y_q <= y_inc2;
        end
      end
    end
  end

  // result assembly
  always_comb begin
    res_d.plane  = cmd_i.plane;
    res_d.dest_x = cur_x_q[COORD_W-1:0];
    res_d.dest_y = cur_y_q[COORD_W-1:0];
    if (cmd_i.plane == PLANE_LUMA) begin
      res_d.sample_first  = luma_q;
      res_d.sample_second = '0;
      res_d.last          = sts_o.luma_end && sts_o.chroma_empty;
    end else begin
      res_d.sample_first  = u_q;
      res_d.sample_second = v_q;
      res_d.last          = sts_o.chroma_end;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_data_o  = res_q;

endmodule
`default_nettype wire

FILE: design/rnv12_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnv12_checker
// Port-level checks of the scaler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rnv12_checker import rnv12_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic pix_valid_i,
  input logic pix_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input res_t res_data_i
);

  // a stalled result transaction keeps its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  // one pixel at a time: the input closes right after a transaction
  a_pix_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i |=> !pix_ready_i)
    else $error("pixel taken while previous one still mapping");

  // luma results carry a zero second sample
  a_luma_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.plane == PLANE_LUMA) |-> res_data_i.sample_second == '0)
    else $error("luma result with nonzero second sample");

  // studio-range luma
  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.plane == PLANE_LUMA) |->
      (res_data_i.sample_first >= 8'd16) && (res_data_i.sample_first <= 8'd235))
    else $error("luma out of studio range");

  // chroma pairs sit on even positions
  a_chroma_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.plane == PLANE_CHROMA) |->
      !res_data_i.dest_x[0] && !res_data_i.dest_y[0])
    else $error("chroma pair at odd position");

endmodule

bind rgb_to_nv12_nearest_scaler_unit rnv12_checker u_rnv12_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams rgb pixels into the nearest-neighbor nv12 scaler under a range of
// source and destination sizes and checks every luma sample and chroma pair
// it emits, in order, against a predictor kept in step with the writes.
// ----------------------------------------------------------------------------

import rnv12_pkg::*;

// predicts the samples of each pixel and holds them until they come out
class nv12_scoreboard;

  localparam int MAX_BURST  = 32;
  localparam int REPORT_MAX = 10;

  logic [DIM_W-1:0] src_width_reg;
  logic [DIM_W-1:0] src_height_reg;
  logic [DIM_W-1:0] dst_width_reg;
  logic [DIM_W-1:0] dst_height_reg;
  int unsigned      src_col;
  int unsigned      src_row;
  res_t             expected_samples[$];
  int unsigned      errors;
  int unsigned      pixels_seen;
  int unsigned      samples_checked;
  int unsigned      size_writes;

  function new();
    src_width_reg   = RST_SRC_WIDTH;
    src_height_reg  = RST_SRC_HEIGHT;
    dst_width_reg   = RST_DST_WIDTH;
    dst_height_reg  = RST_DST_HEIGHT;
    src_col         = 0;
    src_row         = 0;
    errors          = 0;
    pixels_seen     = 0;
    samples_checked = 0;
    size_writes     = 0;
  endfunction

  function int unsigned pending();
    return expected_samples.size();
  endfunction

  // any write brings the position back to the frame start
  function void write_size(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    case (idx)
      REG_SRC_WIDTH:  src_width_reg  = val;
      REG_SRC_HEIGHT: src_height_reg = val;
      REG_DST_WIDTH:  dst_width_reg  = val;
      REG_DST_HEIGHT: dst_height_reg = val;
      default: ;
    endcase
    src_col = 0;
    src_row = 0;
    size_writes++;
  endfunction

  function int unsigned clamp_source(int unsigned s);
    if (s < 1) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return s;
  endfunction

  function int unsigned clamp_dest(int unsigned d, int unsigned s);
    if (d > MAX_UPSCALE * s) d = MAX_UPSCALE * s;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  // first destination index that maps onto source index c or beyond
  function int unsigned first_dest(int unsigned c, int unsigned d, int unsigned s);
    longint unsigned q;
    q = (longint'(c) * d + s - 1) / s;
    if (q > d) q = d;
    return int'(q);
  endfunction

  function void push_sample(ref res_t burst[$], input logic plane,
                            input int unsigned x, input int unsigned y,
                            input int first, input int second);
    res_t s;
    if (burst.size() >= MAX_BURST) return;
    s.plane         = plane;
    s.dest_x        = x[COORD_W-1:0];
    s.dest_y        = y[COORD_W-1:0];
    s.sample_first  = first[SAMP_W-1:0];
    s.sample_second = second[SAMP_W-1:0];
    s.last          = 1'b0;
    burst.push_back(s);
  endfunction

  function void note_pixel(pix_t p);
    int unsigned sw, sh, dw, dh, c, w;
    int unsigned x0, x1, y0, y1, cx1, cy1, x, y;
    int          r, g, b, luma, u, v;
    res_t        burst[$];
    sw = clamp_source(src_width_reg);
    sh = clamp_source(src_height_reg);
    dw = clamp_dest(dst_width_reg, sw);
    dh = clamp_dest(dst_height_reg, sh);
    r  = p.red;
    g  = p.green;
    b  = p.blue;
    c  = (src_col >= sw) ? 0 : src_col;
    w  = (src_row >= sh) ? 0 : src_row;
    pixels_seen++;

    if (dw != 0 && dh != 0) begin
      x0   = first_dest(c, dw, sw);
      x1   = first_dest(c + 1, dw, sw);
      y0   = first_dest(w, dh, sh);
      y1   = first_dest(w + 1, dh, sh);
      luma = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
      for (y = y0; y < y1; y++) begin
        for (x = x0; x < x1; x++) begin
          push_sample(burst, PLANE_LUMA, x, y, luma, 0);
        end
      end
      // chroma only from even source positions, onto even destinations
      if (c[0] == 1'b0 && w[0] == 1'b0) begin
        cx1 = first_dest(c + 2, dw, sw);
        cy1 = first_dest(w + 2, dh, sh);
        u   = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
        v   = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
        for (y = y0 + (y0 & 1); y < cy1; y += 2) begin
          for (x = x0 + (x0 & 1); x < cx1; x += 2) begin
            push_sample(burst, PLANE_CHROMA, x, y, u, v);
          end
        end
      end
    end

    // raster advance with wrap at the frame end
    c++;
    if (c >= sw) begin
      c = 0;
      w++;
      if (w >= sh) w = 0;
    end
    src_col = c;
    src_row = w;

    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) expected_samples.push_back(burst[i]);
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("mismatch: %s", msg);
  endfunction

  function void check_sample(res_t got);
    res_t want;
    if (expected_samples.size() == 0) begin
      flag($sformatf("unexpected sample plane %0d x %0d y %0d %0d/%0d last %0d",
                     got.plane, got.dest_x, got.dest_y, got.sample_first,
                     got.sample_second, got.last));
      return;
    end
    want = expected_samples.pop_front();
    samples_checked++;
    if (got.plane !== want.plane || got.dest_x !== want.dest_x ||
        got.dest_y !== want.dest_y || got.sample_first !== want.sample_first ||
        got.sample_second !== want.sample_second || got.last !== want.last) begin
      flag($sformatf({"expected plane %0d x %0d y %0d %0d/%0d last %0d, ",
                      "got plane %0d x %0d y %0d %0d/%0d last %0d"},
                     want.plane, want.dest_x, want.dest_y, want.sample_first,
                     want.sample_second, want.last,
                     got.plane, got.dest_x, got.dest_y, got.sample_first,
                     got.sample_second, got.last));
    end
  endfunction
endclass

module testbench;
  import rnv12_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 16;
  localparam int TAIL         = 60;
  localparam int RANDOM_ITEMS = 420;
  localparam int CYCLE_LIMIT  = 600000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0]     cfg_data;
  int unsigned          src_idle_pct;
  int unsigned          snk_idle_pct;
  int unsigned          cycle_count;
  int unsigned          random_sent;

  nv12_scoreboard sb;

  rnv12_pix_if pix_ch ();
  rnv12_res_if res_ch ();

  rgb_to_nv12_nearest_scaler_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding",
               cycle_count, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // observe size writes, accepted pixels and emitted samples
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_size(cfg_idx, cfg_data);
      if (pix_ch.valid && pix_ch.ready) sb.note_pixel(pix_ch.data);
      if (res_ch.valid && res_ch.ready) sb.check_sample(res_ch.data);
    end
  end

  function automatic pix_t rgb(int r, int g, int b);
    pix_t p;
    p.red   = r[SAMP_W-1:0];
    p.green = g[SAMP_W-1:0];
    p.blue  = b[SAMP_W-1:0];
    return p;
  endfunction

  // one pixel transaction; valid drops only over an idle gap
  task automatic send_pixel(input pix_t p);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // stop the sender and let the block drain completely
  task automatic drain();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // new frame geometry, written only while the block is idle
  task automatic program_sizes(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                               input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SRC_WIDTH;
    cfg_data <= sw;
    @(posedge clk);
    cfg_idx  <= REG_SRC_HEIGHT;
    cfg_data <= sh;
    @(posedge clk);
    cfg_idx  <= REG_DST_WIDTH;
    cfg_data <= dw;
    @(posedge clk);
    cfg_idx  <= REG_DST_HEIGHT;
    cfg_data <= dh;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // mostly small sources, with zero and oversized values now and then
  function automatic logic [DIM_W-1:0] pick_source();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
      2:       return DIM_W'(MAX_DIM);
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dest(logic [DIM_W-1:0] s);
    int unsigned lim;
    lim = (s == 0) ? MAX_UPSCALE : MAX_UPSCALE * ((s > MAX_DIM) ? MAX_DIM : s);
    if (lim > MAX_DIM) lim = MAX_DIM;
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return DIM_W'($urandom_range(lim, 8191));
      2:       return DIM_W'(lim);
      default: return DIM_W'($urandom_range(1, (lim > 12) ? 12 : lim));
    endcase
  endfunction

  function automatic pix_t pick_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return rgb(($urandom_range(0, 1) != 0) ? 255 : 0,
                             ($urandom_range(0, 1) != 0) ? 255 : 0,
                             ($urandom_range(0, 1) != 0) ? 255 : 0);
    return rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  initial begin
    logic [DIM_W-1:0] sw, sh, dw, dh;
    int unsigned      burst_len;
    sb           = new();
    cycle_count  = 0;
    random_sent  = 0;
    src_idle_pct = 28;
    snk_idle_pct = 61;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_SRC_WIDTH;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.data  = '0;
    res_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes, 1:1 copy: color extremes and primaries
    send_pixel(rgb(0, 0, 0));
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(255, 0, 0));
    send_pixel(rgb(0, 255, 0));
    send_pixel(rgb(0, 0, 255));

    // zero source clamps to 1x1, huge destination clamps to upscale limit
    program_sizes('0, '0, 13'd8191, 13'd8191);
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(128, 64, 200));

    // oversized source, zero destination width: nothing comes out
    program_sizes(13'd8191, 13'd4097, '0, 13'd3);
    send_pixel(rgb(10, 20, 30));
    send_pixel(rgb(200, 100, 50));
    send_pixel(rgb(255, 0, 255));

    // downscale across a frame wrap
    program_sizes(13'd3, 13'd2, 13'd2, 13'd1);
    repeat (7) send_pixel(pick_pixel());

    // widest destination row, single source row upscaled vertically
    program_sizes(13'd4096, 13'd1, 13'd4096, 13'd4);
    repeat (4) send_pixel(pick_pixel());

    // odd upscale ratio; only the top-left source pixel carries chroma
    program_sizes(13'd2, 13'd2, 13'd5, 13'd3);
    repeat (4) send_pixel(pick_pixel());

    // random geometries, each followed by a burst of random pixels
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        src_idle_pct = 28;
        snk_idle_pct = 61;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 61;
        snk_idle_pct = 28;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      sw = pick_source();
      sh = pick_source();
      dw = pick_dest(sw);
      dh = pick_dest(sh);
      program_sizes(sw, sh, dw, dh);
      burst_len = $urandom_range(12, 60);
      repeat (burst_len) begin
        // hold the sender off until everything expected has arrived
        if (random_sent == 60 || $urandom_range(0, 39) == 0) drain();
        send_pixel(pick_pixel());
        random_sent++;
      end
    end

    drain();
    repeat (TAIL) @(posedge clk);

    $display("%0d pixels over %0d size writes, %0d luma and chroma samples checked",
             sb.pixels_seen, sb.size_writes, sb.samples_checked);
    $display("%0d mismatches, %0d samples never seen", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
